/* rtl/core/cddc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package cddc_pkg;

	// Default calendar range
	localparam int unsigned DefEpochYear = 1970;
	localparam int unsigned DefMaxYear   = 9999;

	// Operation codes
	localparam logic [1:0] OP_TO_COUNT = 2'd0;
	localparam logic [1:0] OP_TO_DATE  = 2'd1;
	localparam logic [1:0] OP_NEXT_DAY = 2'd2;
	localparam logic [1:0] OP_PREV_DAY = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic year_step;
		logic month_step;
		logic sum;
		logic emit_fail;
		logic emit_count;
		logic emit_date;
	} cddc_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic count_op;
		logic in_bad;
		logic year_done;
		logic month_done;
	} cddc_sts_t;

	function automatic logic [8:0] year_len(input logic leap);
		return leap ? 9'd366 : 9'd365;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd2:                         len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
			default:                      len = 5'd31;
		endcase
		return len;
	endfunction

	// Days in the year before the first of month m
	function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
		logic [8:0] base;
		case (m)
			4'd2:    base = 9'd31;
			4'd3:    base = 9'd59;
			4'd4:    base = 9'd90;
			4'd5:    base = 9'd120;
			4'd6:    base = 9'd151;
			4'd7:    base = 9'd181;
			4'd8:    base = 9'd212;
			4'd9:    base = 9'd243;
			4'd10:   base = 9'd273;
			4'd11:   base = 9'd304;
			4'd12:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + ((leap && (m > 4'd2)) ? 9'd1 : 9'd0);
	endfunction

endpackage
`default_nettype wire

/* rtl/core/cddc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module cddc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire cddc_pkg::cddc_sts_t sts,
	output cddc_pkg::cddc_cmd_t     cmd,
	output logic                    busy,
	output logic                    done
);
	import cddc_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_YWALK  = 3'd2;
	localparam logic [2:0] S_MWALK  = 3'd3;
	localparam logic [2:0] S_SUM    = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       done_q;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load  = 1'b1;
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.in_bad) begin
					cmd.emit_fail = 1'b1;
					state_nxt     = S_IDLE;
				end else begin
					state_nxt = S_YWALK;
				end
			end
			S_YWALK: begin
				if (sts.year_done) begin
					state_nxt = sts.count_op ? S_MWALK : S_SUM;
				end else begin
					cmd.year_step = 1'b1;
				end
			end
			S_MWALK: begin
				if (sts.month_done) begin
					cmd.emit_count = 1'b1;
					state_nxt      = S_IDLE;
				end else begin
					cmd.month_step = 1'b1;
				end
			end
			S_SUM: begin
				cmd.sum   = 1'b1;
				state_nxt = S_FINISH;
			end
			S_FINISH: begin
				cmd.emit_date = 1'b1;
				state_nxt     = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= cmd.emit_fail | cmd.emit_count | cmd.emit_date;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

/* rtl/core/cddc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module cddc_datapath #(
	parameter int unsigned EPOCH_YEAR = cddc_pkg::DefEpochYear,
	parameter int unsigned MAX_YEAR   = cddc_pkg::DefMaxYear
) (
	input  wire logic                clk,
	input  wire cddc_pkg::cddc_cmd_t cmd,
	input  wire logic [1:0]          op,
	input  wire logic [4:0]          day_in,
	input  wire logic [3:0]          month_in,
	input  wire logic [13:0]         year_in,
	input  wire logic [21:0]         day_count_in,
	output cddc_pkg::cddc_sts_t      sts,
	output logic [4:0]               day_out,
	output logic [3:0]               month_out,
	output logic [13:0]              year_out,
	output logic [21:0]              day_count_out,
	output logic                     valid_res
);
	import cddc_pkg::*;

	// Count of 31 December of the last year
	localparam int unsigned MaxCountInt = 365 * (MAX_YEAR - EPOCH_YEAR + 1)
		+ MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400
		- ((EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100 + (EPOCH_YEAR - 1) / 400);
	localparam logic [21:0] MaxCount    = 22'(MaxCountInt);
	localparam logic [13:0] EpochYear   = 14'(EPOCH_YEAR);
	localparam logic [13:0] MaxYear     = 14'(MAX_YEAR);
	localparam logic [1:0]  EpochMod4   = 2'(EPOCH_YEAR % 4);
	localparam logic [6:0]  EpochMod100 = 7'(EPOCH_YEAR % 100);
	localparam logic [8:0]  EpochMod400 = 9'(EPOCH_YEAR % 400);

	logic [1:0]  op_q;
	logic [4:0]  d_q;
	logic [3:0]  m_q;
	logic [13:0] y_q;
	logic [21:0] cin_q;
	logic [21:0] c_q;
	logic [13:0] yy_q;
	logic [3:0]  mm_q;
	logic [1:0]  mod4_q;
	logic [6:0]  mod100_q;
	logic [8:0]  mod400_q;

	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  walk_mlen;
	logic [4:0]  in_mlen;
	logic [4:0]  prev_mlen;
	logic        date_bad;
	logic        day_ok;
	logic        is_last;
	logic        is_first;

	// Leap year of the walking year, from the residue counters
	assign leap      = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
	assign ylen      = year_len(leap);
	assign walk_mlen = month_len(mm_q, leap);
	assign in_mlen   = month_len(m_q, leap);
	assign prev_mlen = month_len(m_q - 4'd1, leap);

	// Range checks that need no month length, then the day checks
	assign date_bad = (y_q < EpochYear) || (y_q > MaxYear) || (m_q == 4'd0)
		|| (m_q > 4'd12) || (d_q == 5'd0);
	assign day_ok   = (d_q <= in_mlen);
	assign is_last  = (d_q == in_mlen) && (m_q == 4'd12) && (y_q == MaxYear);
	assign is_first = (d_q == 5'd1) && (m_q == 4'd1) && (y_q == EpochYear);

	always_comb begin
		sts.count_op   = (op_q == OP_TO_DATE);
		sts.in_bad     = (op_q == OP_TO_DATE)
			? ((cin_q == 22'd0) || (cin_q > MaxCount)) : date_bad;
		sts.year_done  = (op_q == OP_TO_DATE)
			? ((c_q <= {13'd0, ylen}) || (yy_q == MaxYear)) : (yy_q == y_q);
		sts.month_done = (c_q <= {17'd0, walk_mlen}) || (mm_q == 4'd12);
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op;
			d_q      <= day_in;
			m_q      <= month_in;
			y_q      <= year_in;
			cin_q    <= day_count_in;
			c_q      <= (op == OP_TO_DATE) ? day_count_in : 22'd0;
			yy_q     <= EpochYear;
			mm_q     <= 4'd1;
			mod4_q   <= EpochMod4;
			mod100_q <= EpochMod100;
			mod400_q <= EpochMod400;
		end else if (cmd.year_step) begin
			if (op_q == OP_TO_DATE) begin
				c_q <= c_q - {13'd0, ylen};
			end else begin
				c_q <= c_q + {13'd0, ylen};
			end
			yy_q     <= yy_q + 14'd1;
			mod4_q   <= mod4_q + 2'd1;
			mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
			mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
		end else if (cmd.month_step) begin
			c_q  <= c_q - {17'd0, walk_mlen};
			mm_q <= mm_q + 4'd1;
		end else if (cmd.sum) begin
			c_q <= c_q + {13'd0, days_before(m_q, leap)} + {17'd0, d_q};
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.emit_fail) begin
			valid_res <= 1'b0;
			if (op_q == OP_TO_DATE) begin
				day_out       <= 5'd0;
				month_out     <= 4'd0;
				year_out      <= 14'd0;
				day_count_out <= cin_q;
			end else begin
				day_out       <= d_q;
				month_out     <= m_q;
				year_out      <= y_q;
				day_count_out <= 22'd0;
			end
		end else if (cmd.emit_count) begin
			valid_res     <= 1'b1;
			day_out       <= c_q[4:0];
			month_out     <= mm_q;
			year_out      <= yy_q;
			day_count_out <= cin_q;
		end else if (cmd.emit_date) begin
			// Defaults: the input date echoed with its count
			day_out       <= d_q;
			month_out     <= m_q;
			year_out      <= y_q;
			day_count_out <= c_q;
			valid_res     <= 1'b0;
			if (!day_ok) begin
				day_count_out <= 22'd0;
			end else begin
				case (op_q)
					OP_NEXT_DAY: begin
						if (!is_last) begin
							valid_res     <= 1'b1;
							day_count_out <= c_q + 22'd1;
							if (d_q < in_mlen) begin
								day_out <= d_q + 5'd1;
							end else if (m_q < 4'd12) begin
								day_out   <= 5'd1;
								month_out <= m_q + 4'd1;
							end else begin
								day_out   <= 5'd1;
								month_out <= 4'd1;
								year_out  <= y_q + 14'd1;
							end
						end
					end
					OP_PREV_DAY: begin
						if (!is_first) begin
							valid_res     <= 1'b1;
							day_count_out <= c_q - 22'd1;
							if (d_q > 5'd1) begin
								day_out <= d_q - 5'd1;
							end else if (m_q > 4'd1) begin
								day_out   <= prev_mlen;
								month_out <= m_q - 4'd1;
							end else begin
								day_out   <= 5'd31;
								month_out <= 4'd12;
								year_out  <= y_q - 14'd1;
							end
						end
					end
					default: begin
						valid_res <= 1'b1;
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/core/civil_date_day_count_converter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake          Payload
// command   start / busy       op, day_in, month_in, year_in, day_count_in
// result    done (one cycle)   day_out, month_out, year_out, day_count_out, valid_res
//
// One command at a time. When a field fails the range check, busy ends at that check;
// else the controller walks the years from the epoch (one year per cycle in the
// datapath's accumulator), then, for count to date, fewer than 12 month steps; a day
// past month end costs a walk.
// busy falls as the result is registered, and done rises with it for a single cycle.
// Reset clears the controller only. The receiver cannot stall the result.
module civil_date_day_count_converter_unit #(
	parameter int unsigned EPOCH_YEAR = cddc_pkg::DefEpochYear,
	parameter int unsigned MAX_YEAR   = cddc_pkg::DefMaxYear
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [4:0]  day_in,
	input  wire logic [3:0]  month_in,
	input  wire logic [13:0] year_in,
	input  wire logic [21:0] day_count_in,
	output logic             done,
	output logic [4:0]       day_out,
	output logic [3:0]       month_out,
	output logic [13:0]      year_out,
	output logic [21:0]      day_count_out,
	output logic             valid_res
);
	import cddc_pkg::*;

	cddc_cmd_t cmd;
	cddc_sts_t sts;

	cddc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	cddc_datapath #(
		.EPOCH_YEAR (EPOCH_YEAR),
		.MAX_YEAR   (MAX_YEAR)
	) u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.op            (op),
		.day_in        (day_in),
		.month_in      (month_in),
		.year_in       (year_in),
		.day_count_in  (day_count_in),
		.sts           (sts),
		.day_out       (day_out),
		.month_out     (month_out),
		.year_out      (year_out),
		.day_count_out (day_count_out),
		.valid_res     (valid_res)
	);

endmodule
`default_nettype wire

/* tb/cddc_result_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module cddc_result_checker #(
	parameter int unsigned EPOCH_YEAR = cddc_pkg::DefEpochYear,
	parameter int unsigned MAX_YEAR   = cddc_pkg::DefMaxYear
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  op,
	input  wire logic [4:0]  day_in,
	input  wire logic [3:0]  month_in,
	input  wire logic [13:0] year_in,
	input  wire logic [21:0] day_count_in,
	input  wire logic        done,
	input  wire logic [4:0]  day_out,
	input  wire logic [3:0]  month_out,
	input  wire logic [13:0] year_out,
	input  wire logic [21:0] day_count_out,
	input  wire logic        valid_res,
	output int               pending,
	output int               fail_count
);
	import cddc_pkg::*;

	typedef struct {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [21:0] count;
		logic        ok;
	} date_result_t;

	// Predicted results, oldest first
	date_result_t expected_dates[$];

	function automatic bit leap_year(input int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
		case (m)
			2:           return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	// Leap years in 1..n
	function automatic int unsigned leaps_upto(input int unsigned n);
		return n / 4 - n / 100 + n / 400;
	endfunction

	function automatic bit in_calendar(input int unsigned d, input int unsigned m,
			input int unsigned y);
		if (y < EPOCH_YEAR || y > MAX_YEAR) return 1'b0;
		if (m < 1 || m > 12) return 1'b0;
		return d >= 1 && d <= month_days(m, y);
	endfunction

	// Day number of a valid date, 1 Jan of the epoch year being day 1
	function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
			input int unsigned y);
		int unsigned n;
		n = 365 * (y - EPOCH_YEAR) + leaps_upto(y - 1) - leaps_upto(EPOCH_YEAR - 1);
		for (int unsigned k = 1; k < m; k++)
			n += month_days(k, y);
		return n + d;
	endfunction

	// Date of a day number in range
	function automatic void civil_date(input int unsigned n, output int unsigned d,
			output int unsigned m, output int unsigned y);
		y = EPOCH_YEAR;
		m = 1;
		while (n > (leap_year(y) ? 366 : 365) && y < MAX_YEAR) begin
			n -= leap_year(y) ? 366 : 365;
			y++;
		end
		while (n > month_days(m, y) && m < 12) begin
			n -= month_days(m, y);
			m++;
		end
		d = n;
	endfunction

	function automatic date_result_t predict_conversion(input logic [1:0] o,
			input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
			input logic [21:0] c);
		date_result_t r;
		int unsigned last_day, n, rd, rm, ry;
		last_day = day_number(31, 12, MAX_YEAR);
		r = '{day: d, month: m, year: y, count: '0, ok: 1'b0};
		if (o == OP_TO_DATE) begin
			r.count = c;
			if (c >= 1 && c <= last_day) begin
				civil_date(c, rd, rm, ry);
				r = '{day: 5'(rd), month: 4'(rm), year: 14'(ry), count: c, ok: 1'b1};
			end else begin
				r.day = '0;
				r.month = '0;
				r.year = '0;
			end
		end else if (in_calendar(d, m, y)) begin
			n = day_number(d, m, y);
			r.count = 22'(n);
			case (o)
				OP_TO_COUNT: r.ok = 1'b1;
				OP_NEXT_DAY: if (n < last_day) begin
					civil_date(n + 1, rd, rm, ry);
					r = '{day: 5'(rd), month: 4'(rm), year: 14'(ry), count: 22'(n + 1),
						ok: 1'b1};
				end
				OP_PREV_DAY: if (n > 1) begin
					civil_date(n - 1, rd, rm, ry);
					r = '{day: 5'(rd), month: 4'(rm), year: 14'(ry), count: 22'(n - 1),
						ok: 1'b1};
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	initial begin
		pending = 0;
		fail_count = 0;
	end

	// Check the result first, then record any command taken at the same edge
	always @(posedge clk) begin
		date_result_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_dates.size() == 0) begin
					$error("result with no command outstanding");
					fail_count++;
				end else begin
					want = expected_dates.pop_front();
					if (day_out !== want.day) begin
						$error("day_out: expected %0d, got %0d", want.day, day_out);
						fail_count++;
					end
					if (month_out !== want.month) begin
						$error("month_out: expected %0d, got %0d", want.month, month_out);
						fail_count++;
					end
					if (year_out !== want.year) begin
						$error("year_out: expected %0d, got %0d", want.year, year_out);
						fail_count++;
					end
					if (day_count_out !== want.count) begin
						$error("day_count_out: expected %0d, got %0d", want.count,
							day_count_out);
						fail_count++;
					end
					if (valid_res !== want.ok) begin
						$error("valid_res: expected %0d, got %0d", want.ok, valid_res);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				expected_dates.push_back(predict_conversion(op, day_in, month_in, year_in,
					day_count_in));
			pending = expected_dates.size();
		end
	end

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import cddc_pkg::*;

	// Day number of 31 Dec 9999 with the default epoch
	localparam int unsigned LAST_DAY = 2932897;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  op = OP_TO_COUNT;
	logic [4:0]  day_in = '0;
	logic [3:0]  month_in = '0;
	logic [13:0] year_in = '0;
	logic [21:0] day_count_in = '0;
	logic        busy, done, valid_res;
	logic [4:0]  day_out;
	logic [3:0]  month_out;
	logic [13:0] year_out;
	logic [21:0] day_count_out;
	int          pending, fail_count;
	int          burst_left = 0;

	always #5 clk = ~clk;

	civil_date_day_count_converter_unit dut (
		.clk, .arst_n, .start, .busy, .op, .day_in, .month_in, .year_in, .day_count_in,
		.done, .day_out, .month_out, .year_out, .day_count_out, .valid_res
	);

	cddc_result_checker date_check (
		.clk, .arst_n, .start, .busy, .op, .day_in, .month_in, .year_in, .day_count_in,
		.done, .day_out, .month_out, .year_out, .day_count_out, .valid_res,
		.pending, .fail_count
	);

	// Issue one transaction; called and returns at a falling edge
	task automatic send_cmd(input logic [1:0] o, input logic [4:0] d, input logic [3:0] m,
			input logic [13:0] y, input logic [21:0] c);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		start <= 1'b1;
		op <= o;
		day_in <= d;
		month_in <= m;
		year_in <= y;
		day_count_in <= c;
		// busy is stable between edges, so a low value here means the next edge takes it
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	// Hold off until every result is back
	task automatic drain;
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		@(negedge clk);
		burst_left = 0;
	endtask

	initial begin
		#60_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		logic [1:0]  o;
		logic [4:0]  d;
		logic [3:0]  m;
		logic [13:0] y;
		logic [21:0] c;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: range ends, leap rules, malformed fields, wrap at both ends
		send_cmd(OP_TO_COUNT, 5'd1, 4'd1, 14'd1970, 22'd0);
		send_cmd(OP_TO_COUNT, 5'd31, 4'd12, 14'd9999, 22'h3FFFFF);
		send_cmd(OP_TO_COUNT, 5'd29, 4'd2, 14'd2000, 22'd0);
		send_cmd(OP_TO_COUNT, 5'd29, 4'd2, 14'd2100, 22'd0);
		send_cmd(OP_TO_COUNT, 5'd29, 4'd2, 14'd2024, 22'd0);
		send_cmd(OP_TO_COUNT, 5'd29, 4'd2, 14'd2023, 22'd0);
		send_cmd(OP_TO_COUNT, 5'd0, 4'd5, 14'd1999, 22'd0);
		send_cmd(OP_TO_COUNT, 5'd31, 4'd4, 14'd1999, 22'd0);
		send_cmd(OP_TO_COUNT, 5'd10, 4'd0, 14'd1999, 22'd0);
		send_cmd(OP_TO_COUNT, 5'd10, 4'd13, 14'd1999, 22'd0);
		send_cmd(OP_TO_COUNT, 5'd31, 4'd15, 14'h3FFF, 22'h3FFFFF);
		send_cmd(OP_TO_COUNT, 5'd31, 4'd12, 14'd1969, 22'd0);
		send_cmd(OP_TO_COUNT, 5'd1, 4'd1, 14'd0, 22'd0);
		send_cmd(OP_TO_DATE, 5'd0, 4'd0, 14'd0, 22'd0);
		send_cmd(OP_TO_DATE, 5'd31, 4'd15, 14'h3FFF, 22'd1);
		send_cmd(OP_TO_DATE, 5'd0, 4'd0, 14'd0, 22'(LAST_DAY));
		send_cmd(OP_TO_DATE, 5'd0, 4'd0, 14'd0, 22'(LAST_DAY + 1));
		send_cmd(OP_TO_DATE, 5'd0, 4'd0, 14'd0, 22'h3FFFFF);
		send_cmd(OP_TO_DATE, 5'd0, 4'd0, 14'd0, 22'd790);
		send_cmd(OP_NEXT_DAY, 5'd31, 4'd12, 14'd9999, 22'd0);
		send_cmd(OP_NEXT_DAY, 5'd31, 4'd12, 14'd2023, 22'd0);
		send_cmd(OP_NEXT_DAY, 5'd28, 4'd2, 14'd2024, 22'd0);
		send_cmd(OP_NEXT_DAY, 5'd30, 4'd2, 14'd2024, 22'd0);
		send_cmd(OP_PREV_DAY, 5'd1, 4'd1, 14'd1970, 22'd0);
		send_cmd(OP_PREV_DAY, 5'd1, 4'd3, 14'd2024, 22'd0);
		send_cmd(OP_PREV_DAY, 5'd1, 4'd1, 14'd2000, 22'd0);
		drain();

		// Random: mostly well-formed commands near the epoch, some far out, some noise
		for (int i = 0; i < 74; i++) begin
			o = 2'($urandom_range(0, 3));
			d = 5'($urandom);
			m = 4'($urandom);
			y = 14'($urandom);
			c = 22'($urandom);
			if ($urandom_range(0, 3) != 0) begin
				y = ($urandom_range(0, 9) < 8) ? 14'($urandom_range(1970, 2100))
					: 14'($urandom_range(1970, 9999));
				m = 4'($urandom_range(1, 12));
				case ($urandom_range(0, 5))
					0:       d = 5'($urandom_range(28, 31));
					1:       begin d = 5'd31; m = 4'd12; end
					2:       begin d = 5'd1; m = 4'd1; end
					default: d = 5'($urandom_range(1, 28));
				endcase
				if (o == OP_TO_DATE)
					c = ($urandom_range(0, 9) < 8) ? 22'($urandom_range(1, 50000))
						: 22'($urandom_range(1, LAST_DAY));
			end
			send_cmd(o, d, m, y, c);
			if (i % 37 == 36)
				drain();
		end

		drain();
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
